FILE: rtl/core/eth_l4x_pkg.sv
package eth_l4x_pkg;

    localparam int CNT_W      = 16;
    localparam int CODE_W     = 5;
    localparam int VALUE_W    = 48;
    localparam int NUM_FIELDS = 17;

    localparam int ETH_LEN    = 14;
    localparam int IP_MIN_LEN = 20;
    localparam int HB_L4      = ETH_LEN + IP_MIN_LEN;
    localparam int L4_BYTES   = 20;
    localparam int HB_BYTES   = HB_L4 + L4_BYTES;
    localparam int STEP_W     = $clog2(HB_BYTES);
    localparam int L4_OFF_W   = 7;
    localparam int POFF_W     = 8;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  MIN_WORDS      = 4'd5;
    localparam int          UDP_HDR_LEN    = 8;

    typedef enum logic [CODE_W-1:0] {
        FC_DSTMAC   = 5'd0,
        FC_SRCMAC   = 5'd1,
        FC_PROTO    = 5'd2,
        FC_SRCIP    = 5'd3,
        FC_DSTIP    = 5'd4,
        FC_IPID     = 5'd5,
        FC_TTL      = 5'd6,
        FC_SPORT    = 5'd7,
        FC_DPORT    = 5'd8,
        FC_SEQ      = 5'd9,
        FC_ACK      = 5'd10,
        FC_URGPTR   = 5'd11,
        FC_URG      = 5'd12,
        FC_ICMPTYPE = 5'd13,
        FC_PAYOFF   = 5'd14,
        FC_PAYLEN   = 5'd15,
        FC_FRAMELEN = 5'd16
    } field_code_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_DER1 = 5'b00100,
        ST_DER2 = 5'b01000,
        ST_EMIT = 5'b10000
    } eng_state_t;

endpackage

FILE: rtl/core/eth_ipv4_l4_header_field_extractor_core.sv
// channel | direction | words                          | handshake
// s_      | in        | s_packet_byte, s_last_byte     | s_valid / s_ready
// m_      | out       | m_field_code, m_present,       | m_valid / m_ready
//         |           | m_field_value, m_last_field    |
// cfg_    | in        | cfg_wr_data (field enable)     | cfg_wr_en, no wait
//
// One input word per cycle while s_ready; header bytes go to a two-bank memory.
// At frame end the bank is handed to the extraction engine: 54 memory reads
// (one port), two derive states, then one emit step per field code (17).
// A frame streams without stall into the free bank while the engine works
// on the previous one; s_ready drops when both banks are held.
// Reset is synchronous on aresetn: banks empty, count zero, all fields enabled.
module eth_ipv4_l4_header_field_extractor_core #(
    parameter int HEADER_BYTES    = 128,
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [7:0]                             s_packet_byte,
    input  logic                                   s_last_byte,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [eth_l4x_pkg::CODE_W-1:0]         m_field_code,
    output logic                                   m_present,
    output logic [eth_l4x_pkg::VALUE_W-1:0]        m_field_value,
    output logic                                   m_last_field,
    input  logic                                   cfg_wr_en,
    input  logic [eth_l4x_pkg::NUM_FIELDS-1:0]     cfg_wr_data
);
    import eth_l4x_pkg::*;

    localparam int OFF_W     = $clog2(HEADER_BYTES);
    localparam int MEM_DEPTH = 2 ** (OFF_W + 1);

    logic [7:0]            mem [MEM_DEPTH];
    logic [7:0]            rdata_reg;
    logic [OFF_W:0]        raddr;
    logic [OFF_W-1:0]      rd_off;
    logic [L4_OFF_W-1:0]   rd_off7;

    logic [NUM_FIELDS-1:0] mask_reg;
    logic [CNT_W-1:0]      byte_count_reg;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W-1:0]      len_reg [2];
    logic [1:0]            bank_full_reg, bank_full_next;
    logic                  wr_bank_reg, rd_bank_reg;
    logic                  in_fire;

    eng_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  cap_vld_reg;
    logic [STEP_W-1:0]     cap_idx_reg;
    logic [7:0]            hbuf_reg [HB_BYTES];
    logic [CNT_W-1:0]      eng_len_reg;

    logic [L4_OFF_W-1:0]   l4c;
    logic                  ipok, proto_ok, l4ok, tcp, udp, icmp, tcp_doff;
    logic [3:0]            doff;
    logic                  pcand;
    logic [POFF_W-1:0]     poff;

    logic                  ipok_reg, proto_ok_reg, tcp_reg, udp_reg, icmp_reg;
    logic [L4_OFF_W-1:0]   l4_reg;
    logic                  pcand_reg, pok_reg;
    logic [POFF_W-1:0]     poff_reg;
    logic [CNT_W-1:0]      paylen_reg;

    field_code_t           code_reg;
    logic                  emit_go, emit_done, emit_on;
    logic                  f_cond;
    logic [POFF_W-1:0]     f_need;
    logic [VALUE_W-1:0]    f_raw;
    logic                  f_pres;
    logic [NUM_FIELDS-1:0] mask_above;

    logic                  m_valid_reg;
    field_code_t           m_code_reg;
    logic                  m_present_reg;
    logic [VALUE_W-1:0]    m_value_reg;
    logic                  m_last_reg;

    assign s_ready   = !bank_full_reg[wr_bank_reg];
    assign in_fire   = s_valid && s_ready;
    assign count_inc = (byte_count_reg < CNT_W'(MAX_FRAME_BYTES)) ?
                       byte_count_reg + 1'b1 : byte_count_reg;

    always_ff @(posedge aclk) begin
        if (in_fire && (byte_count_reg < CNT_W'(HEADER_BYTES))) begin
            mem[{wr_bank_reg, byte_count_reg[OFF_W-1:0]}] <= s_packet_byte;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '1;
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            wr_bank_reg    <= 1'b0;
        end else if (in_fire) begin
            if (s_last_byte) begin
                byte_count_reg <= '0;
                wr_bank_reg    <= !wr_bank_reg;
            end else begin
                byte_count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_last_byte) begin
            len_reg[wr_bank_reg] <= count_inc;
        end
    end

    always_comb begin
        bank_full_next = bank_full_reg;
        if (in_fire && s_last_byte) begin
            bank_full_next[wr_bank_reg] = 1'b1;
        end
        if (emit_done) begin
            bank_full_next[rd_bank_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_full_reg <= '0;
            rd_bank_reg   <= 1'b0;
        end else begin
            bank_full_reg <= bank_full_next;
            if (emit_done) begin
                rd_bank_reg <= !rd_bank_reg;
            end
        end
    end

    // extraction engine
    assign l4c = L4_OFF_W'(ETH_LEN) + {1'b0, hbuf_reg[ETH_LEN][3:0], 2'b00};

    always_comb begin
        if (step_reg < STEP_W'(HB_L4)) begin
            rd_off7 = L4_OFF_W'(step_reg);
        end else begin
            rd_off7 = l4c + L4_OFF_W'(step_reg - STEP_W'(HB_L4));
        end
        rd_off = OFF_W'(rd_off7);
        raddr  = {rd_bank_reg, rd_off};
    end

    assign emit_go   = !m_valid_reg || m_ready;
    assign emit_on   = (state_reg == ST_EMIT) && emit_go;
    assign emit_done = emit_on && (code_reg == FC_FRAMELEN);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (bank_full_reg[rd_bank_reg]) state_next = ST_READ;
            ST_READ: if (step_reg == STEP_W'(HB_BYTES - 1)) state_next = ST_DER1;
            ST_DER1: state_next = ST_DER2;
            ST_DER2: state_next = ST_EMIT;
            ST_EMIT: if (emit_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            cap_vld_reg <= 1'b0;
            code_reg    <= FC_DSTMAC;
        end else begin
            state_reg   <= state_next;
            cap_vld_reg <= (state_reg == ST_READ);
            if (state_reg == ST_IDLE) begin
                step_reg <= '0;
                code_reg <= FC_DSTMAC;
            end else if (state_reg == ST_READ) begin
                step_reg <= step_reg + 1'b1;
            end
            if (emit_on && !emit_done) begin
                code_reg <= field_code_t'(code_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cap_idx_reg <= step_reg;
        if (cap_vld_reg) begin
            hbuf_reg[cap_idx_reg] <= rdata_reg;
        end
        if (state_reg == ST_IDLE) begin
            eng_len_reg <= len_reg[rd_bank_reg];
        end
    end

    // derive protocol flags and payload offset
    always_comb begin
        ipok     = (eng_len_reg >= CNT_W'(ETH_LEN)) &&
                   ({hbuf_reg[12], hbuf_reg[13]} == ETHERTYPE_IPV4);
        proto_ok = ipok && (eng_len_reg >= CNT_W'(ETH_LEN + 10));
        l4ok     = proto_ok && (hbuf_reg[ETH_LEN][3:0] >= MIN_WORDS);
        tcp      = l4ok && (hbuf_reg[ETH_LEN + 9] == PROTO_TCP);
        udp      = l4ok && (hbuf_reg[ETH_LEN + 9] == PROTO_UDP);
        icmp     = l4ok && (hbuf_reg[ETH_LEN + 9] == PROTO_ICMP);
        doff     = hbuf_reg[HB_L4 + 12][7:4];
        tcp_doff = tcp && (CNT_W'({1'b0, l4c} + 8'd13) <= eng_len_reg);
        if (tcp_doff) begin
            pcand = (doff >= MIN_WORDS);
            poff  = {1'b0, l4c} + {2'b00, doff, 2'b00};
        end else if (udp) begin
            pcand = 1'b1;
            poff  = {1'b0, l4c} + POFF_W'(UDP_HDR_LEN);
        end else begin
            pcand = 1'b0;
            poff  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DER1) begin
            ipok_reg     <= ipok;
            proto_ok_reg <= proto_ok;
            tcp_reg      <= tcp;
            udp_reg      <= udp;
            icmp_reg     <= icmp;
            l4_reg       <= l4c;
            pcand_reg    <= pcand;
            poff_reg     <= poff;
        end
        if (state_reg == ST_DER2) begin
            pok_reg    <= pcand_reg && (CNT_W'(poff_reg) <= eng_len_reg);
            paylen_reg <= eng_len_reg - CNT_W'(poff_reg);
        end
    end

    // per-field select
    always_comb begin
        f_cond = 1'b0;
        f_need = '0;
        f_raw  = '0;
        case (code_reg)
            FC_DSTMAC: begin
                f_cond = 1'b1;
                f_need = POFF_W'(6);
                f_raw  = VALUE_W'({hbuf_reg[0], hbuf_reg[1], hbuf_reg[2],
                                   hbuf_reg[3], hbuf_reg[4], hbuf_reg[5]});
            end
            FC_SRCMAC: begin
                f_cond = 1'b1;
                f_need = POFF_W'(12);
                f_raw  = VALUE_W'({hbuf_reg[6], hbuf_reg[7], hbuf_reg[8],
                                   hbuf_reg[9], hbuf_reg[10], hbuf_reg[11]});
            end
            FC_PROTO: begin
                f_cond = proto_ok_reg;
                f_raw  = VALUE_W'(hbuf_reg[ETH_LEN + 9]);
            end
            FC_SRCIP: begin
                f_cond = ipok_reg;
                f_need = POFF_W'(ETH_LEN + 16);
                f_raw  = VALUE_W'({hbuf_reg[ETH_LEN + 12], hbuf_reg[ETH_LEN + 13],
                                   hbuf_reg[ETH_LEN + 14], hbuf_reg[ETH_LEN + 15]});
            end
            FC_DSTIP: begin
                f_cond = ipok_reg;
                f_need = POFF_W'(ETH_LEN + 20);
                f_raw  = VALUE_W'({hbuf_reg[ETH_LEN + 16], hbuf_reg[ETH_LEN + 17],
                                   hbuf_reg[ETH_LEN + 18], hbuf_reg[ETH_LEN + 19]});
            end
            FC_IPID: begin
                f_cond = ipok_reg;
                f_need = POFF_W'(ETH_LEN + 6);
                f_raw  = VALUE_W'({hbuf_reg[ETH_LEN + 4], hbuf_reg[ETH_LEN + 5]});
            end
            FC_TTL: begin
                f_cond = ipok_reg;
                f_need = POFF_W'(ETH_LEN + 9);
                f_raw  = VALUE_W'(hbuf_reg[ETH_LEN + 8]);
            end
            FC_SPORT: begin
                f_cond = tcp_reg || udp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(2);
                f_raw  = VALUE_W'({hbuf_reg[HB_L4], hbuf_reg[HB_L4 + 1]});
            end
            FC_DPORT: begin
                f_cond = tcp_reg || udp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(4);
                f_raw  = VALUE_W'({hbuf_reg[HB_L4 + 2], hbuf_reg[HB_L4 + 3]});
            end
            FC_SEQ: begin
                f_cond = tcp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(8);
                f_raw  = VALUE_W'({hbuf_reg[HB_L4 + 4], hbuf_reg[HB_L4 + 5],
                                   hbuf_reg[HB_L4 + 6], hbuf_reg[HB_L4 + 7]});
            end
            FC_ACK: begin
                f_cond = tcp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(12);
                f_raw  = VALUE_W'({hbuf_reg[HB_L4 + 8], hbuf_reg[HB_L4 + 9],
                                   hbuf_reg[HB_L4 + 10], hbuf_reg[HB_L4 + 11]});
            end
            FC_URGPTR: begin
                f_cond = tcp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(20);
                f_raw  = VALUE_W'({hbuf_reg[HB_L4 + 18], hbuf_reg[HB_L4 + 19]});
            end
            FC_URG: begin
                f_cond = tcp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(14);
                f_raw  = VALUE_W'(hbuf_reg[HB_L4 + 13][5]);
            end
            FC_ICMPTYPE: begin
                f_cond = icmp_reg;
                f_need = {1'b0, l4_reg} + POFF_W'(1);
                f_raw  = VALUE_W'(hbuf_reg[HB_L4]);
            end
            FC_PAYOFF: begin
                f_cond = pok_reg;
                f_raw  = VALUE_W'(poff_reg);
            end
            FC_PAYLEN: begin
                f_cond = pok_reg;
                f_raw  = VALUE_W'(paylen_reg);
            end
            FC_FRAMELEN: begin
                f_cond = 1'b1;
                f_raw  = VALUE_W'(eng_len_reg);
            end
            default: begin
                f_cond = 1'b0;
            end
        endcase
        f_pres     = f_cond && (CNT_W'(f_need) <= eng_len_reg);
        mask_above = (mask_reg >> code_reg) >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_on && mask_reg[code_reg]) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_on && mask_reg[code_reg]) begin
            m_code_reg    <= code_reg;
            m_present_reg <= f_pres;
            m_value_reg   <= f_pres ? f_raw : '0;
            m_last_reg    <= (mask_above == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_field_code  = m_code_reg;
    assign m_present     = m_present_reg;
    assign m_field_value = m_value_reg;
    assign m_last_field  = m_last_reg;

endmodule

FILE: test/eth_ipv4_l4_header_field_extractor_core_test.sv
`timescale 1ns / 100ps

module eth_ipv4_l4_header_field_extractor_core_test;
    import eth_l4x_pkg::*;

    localparam int STORE_BYTES = 128;
    localparam int COUNT_MAX = 65535;
    localparam logic [NUM_FIELDS-1:0] ALL_FIELDS = '1;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [7:0] PROTO_GRE = 8'd47;

    typedef struct {
        field_code_t        code;
        logic               present;
        logic [VALUE_W-1:0] value;
        logic               is_last;
    } field_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_packet_byte;
    logic                  s_last_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [CODE_W-1:0]     m_field_code;
    logic                  m_present;
    logic [VALUE_W-1:0]    m_field_value;
    logic                  m_last_field;
    logic                  cfg_wr_en;
    logic [NUM_FIELDS-1:0] cfg_wr_data;

    logic [7:0]            hdr_mem [STORE_BYTES];
    int                    frame_count;
    logic [NUM_FIELDS-1:0] enable_mask;
    field_word_t           expected_words[$];
    logic [7:0]            frame_buf[$];
    int                    fail_count = 0;
    int                    cycle_count = 0;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;

    eth_ipv4_l4_header_field_extractor_core #(
        .HEADER_BYTES    (STORE_BYTES),
        .MAX_FRAME_BYTES (COUNT_MAX)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_packet_byte (s_packet_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_code  (m_field_code),
        .m_present     (m_present),
        .m_field_value (m_field_value),
        .m_last_field  (m_last_field),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] hdr_read(input int off, input int n);
        logic [VALUE_W-1:0] v;
        int i;
        v = '0;
        for (i = 0; i < n; i++) begin
            v = {v[VALUE_W-9:0], (off + i < STORE_BYTES) ? hdr_mem[off + i] : 8'h00};
        end
        return v;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
        bit                 pres [NUM_FIELDS];
        logic [VALUE_W-1:0] val [NUM_FIELDS];
        int                 len, l4, ihl, doff, poff, c, top;
        logic [7:0]         proto;
        bit                 ipok, l4ok, tcp, udp, icmp, pok;
        field_word_t        w;
        if (frame_count < STORE_BYTES) hdr_mem[frame_count] = b;
        if (frame_count < COUNT_MAX) frame_count++;
        if (!is_last) return;
        len = frame_count;
        frame_count = 0;
        for (c = 0; c < NUM_FIELDS; c++) begin
            pres[c] = 1'b0;
            val[c] = '0;
        end

        pres[FC_DSTMAC] = (6 <= len);
        pres[FC_SRCMAC] = (12 <= len);
        if (pres[FC_DSTMAC]) val[FC_DSTMAC] = hdr_read(0, 6);
        if (pres[FC_SRCMAC]) val[FC_SRCMAC] = hdr_read(6, 6);

        ipok = (len >= ETH_LEN) && (hdr_read(12, 2) == ETHERTYPE_IPV4);
        pres[FC_PROTO] = ipok && (ETH_LEN + 10 <= len);
        pres[FC_SRCIP] = ipok && (ETH_LEN + 16 <= len);
        pres[FC_DSTIP] = ipok && (ETH_LEN + 20 <= len);
        pres[FC_IPID] = ipok && (ETH_LEN + 6 <= len);
        pres[FC_TTL] = ipok && (ETH_LEN + 9 <= len);
        proto = 8'h00;
        if (pres[FC_PROTO]) begin
            proto = 8'(hdr_read(ETH_LEN + 9, 1));
            val[FC_PROTO] = VALUE_W'(proto);
        end
        if (pres[FC_SRCIP]) val[FC_SRCIP] = hdr_read(ETH_LEN + 12, 4);
        if (pres[FC_DSTIP]) val[FC_DSTIP] = hdr_read(ETH_LEN + 16, 4);
        if (pres[FC_IPID]) val[FC_IPID] = hdr_read(ETH_LEN + 4, 2);
        if (pres[FC_TTL]) val[FC_TTL] = hdr_read(ETH_LEN + 8, 1);

        l4ok = 1'b0;
        l4 = 0;
        if (pres[FC_PROTO]) begin
            ihl = int'(hdr_mem[ETH_LEN][3:0]);
            if (ihl >= MIN_WORDS) begin
                l4ok = 1'b1;
                l4 = ETH_LEN + ihl * 4;
            end
        end
        tcp = l4ok && (proto == PROTO_TCP);
        udp = l4ok && (proto == PROTO_UDP);
        icmp = l4ok && (proto == PROTO_ICMP);

        pres[FC_SPORT] = (tcp || udp) && (l4 + 2 <= len);
        pres[FC_DPORT] = (tcp || udp) && (l4 + 4 <= len);
        pres[FC_SEQ] = tcp && (l4 + 8 <= len);
        pres[FC_ACK] = tcp && (l4 + 12 <= len);
        pres[FC_URGPTR] = tcp && (l4 + 20 <= len);
        pres[FC_URG] = tcp && (l4 + 14 <= len);
        pres[FC_ICMPTYPE] = icmp && (l4 + 1 <= len);
        if (pres[FC_SPORT]) val[FC_SPORT] = hdr_read(l4, 2);
        if (pres[FC_DPORT]) val[FC_DPORT] = hdr_read(l4 + 2, 2);
        if (pres[FC_SEQ]) val[FC_SEQ] = hdr_read(l4 + 4, 4);
        if (pres[FC_ACK]) val[FC_ACK] = hdr_read(l4 + 8, 4);
        if (pres[FC_URGPTR]) val[FC_URGPTR] = hdr_read(l4 + 18, 2);
        if (pres[FC_URG]) val[FC_URG] = (hdr_read(l4 + 13, 1) >> 5) & 48'h1;
        if (pres[FC_ICMPTYPE]) val[FC_ICMPTYPE] = hdr_read(l4, 1);

        pok = 1'b0;
        poff = 0;
        if (tcp && (l4 + 13 <= len)) begin
            doff = int'(hdr_read(l4 + 12, 1) >> 4);
            if (doff >= MIN_WORDS) begin
                poff = l4 + doff * 4;
                pok = (poff <= len);
            end
        end else if (udp) begin
            poff = l4 + UDP_HDR_LEN;
            pok = (poff <= len);
        end
        pres[FC_PAYOFF] = pok;
        pres[FC_PAYLEN] = pok;
        if (pok) begin
            val[FC_PAYOFF] = VALUE_W'(poff);
            val[FC_PAYLEN] = VALUE_W'(len - poff);
        end
        pres[FC_FRAMELEN] = 1'b1;
        val[FC_FRAMELEN] = VALUE_W'(len);

        top = -1;
        for (c = 0; c < NUM_FIELDS; c++) begin
            if (enable_mask[c]) top = c;
        end
        for (c = 0; c < NUM_FIELDS; c++) begin
            if (enable_mask[c]) begin
                w.code = field_code_t'(c);
                w.present = pres[c];
                w.value = val[c];
                w.is_last = (c == top);
                expected_words.push_back(w);
            end
        end
    endfunction

    function automatic void check_word();
        field_word_t w;
        bit bad;
        bad = 1'b0;
        if (expected_words.size() == 0) begin
            $display("%0t: word with none expected: code %0d present %0b value %h last %0b",
                     $time, m_field_code, m_present, m_field_value, m_last_field);
            fail_count++;
            return;
        end
        w = expected_words.pop_front();
        if (m_field_code !== w.code) begin
            $display("%0t: field_code expected %0d actual %0d", $time, w.code, m_field_code);
            bad = 1'b1;
        end
        if (m_present !== w.present) begin
            $display("%0t: present (code %0d) expected %0b actual %0b",
                     $time, w.code, w.present, m_present);
            bad = 1'b1;
        end
        if (m_field_value !== w.value) begin
            $display("%0t: field_value (code %0d) expected %h actual %h",
                     $time, w.code, w.value, m_field_value);
            bad = 1'b1;
        end
        if (m_last_field !== w.is_last) begin
            $display("%0t: last_field (code %0d) expected %0b actual %0b",
                     $time, w.code, w.is_last, m_last_field);
            bad = 1'b1;
        end
        if (bad) fail_count++;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) absorb_byte(s_packet_byte, s_last_byte);
            if (m_valid && m_ready) check_word();
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_packet_byte <= b;
        s_last_byte <= is_last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // drop valid, drain every expected word, then cover an engine pass with no output
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mask(input logic [NUM_FIELDS-1:0] m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        enable_mask = m;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic gen_frame(input bit is_ipv4, input int ihl, input logic [7:0] proto,
                             input int doff, input int pay_len, input int cut_len);
        int i, ip_len, l4_len;
        logic [15:0] etype;
        frame_buf.delete();
        for (i = 0; i < 12; i++) frame_buf.push_back(8'($urandom));
        etype = is_ipv4 ? ETHERTYPE_IPV4 : 16'($urandom);
        if (!is_ipv4 && etype == ETHERTYPE_IPV4) etype = 16'h86dd;
        frame_buf.push_back(etype[15:8]);
        frame_buf.push_back(etype[7:0]);
        ip_len = (ihl >= 5) ? ihl * 4 : IP_MIN_LEN;
        frame_buf.push_back({4'h4, 4'(ihl)});
        for (i = 1; i < ip_len; i++) frame_buf.push_back((i == 9) ? proto : 8'($urandom));
        if (proto == PROTO_TCP) l4_len = (doff >= 5) ? doff * 4 : L4_BYTES;
        else l4_len = UDP_HDR_LEN;
        for (i = 0; i < l4_len; i++) begin
            frame_buf.push_back((proto == PROTO_TCP && i == 12) ? {4'(doff), 4'($urandom)}
                                                               : 8'($urandom));
        end
        for (i = 0; i < pay_len; i++) frame_buf.push_back(8'($urandom));
        while (cut_len > 0 && frame_buf.size() > cut_len) void'(frame_buf.pop_back());
    endtask

    task automatic test_default_mask();
        gen_frame(1, 5, PROTO_TCP, 5, 0, 0);
        send_frame();
        settle();
    endtask

    task automatic test_protocols();
        gen_frame(1, 5, PROTO_UDP, 0, 0, 0);
        send_frame();
        gen_frame(1, 5, PROTO_ICMP, 0, 0, 35);
        send_frame();
        gen_frame(1, 5, PROTO_GRE, 0, 0, 36);
        send_frame();
        gen_frame(0, 5, PROTO_TCP, 5, 0, 16);
        send_frame();
        // malformed IHL
        gen_frame(1, 4, PROTO_UDP, 0, 0, 36);
        send_frame();
        // malformed TCP data offset
        gen_frame(1, 5, PROTO_TCP, 4, 0, 47);
        send_frame();
        settle();
    endtask

    task automatic test_short_frames();
        int cut_lens[3] = '{1, 13, 50};
        foreach (cut_lens[k]) begin
            gen_frame(1, 5, PROTO_TCP, 5, 0, cut_lens[k]);
            send_frame();
        end
        settle();
    endtask

    task automatic test_extreme_bytes();
        gen_frame(1, 5, PROTO_TCP, 5, 0, 0);
        // hold ethertype, IHL, protocol and data offset
        foreach (frame_buf[i]) begin
            if (!(i inside {12, 13, 14, 23, 46})) frame_buf[i] = 8'hff;
        end
        send_frame();
        settle();
    endtask

    task automatic test_field_masks();
        logic [NUM_FIELDS-1:0] masks[3] = '{17'h00000, 17'h10001, 17'h0aaaa};
        foreach (masks[k]) begin
            write_mask(masks[k]);
            gen_frame(1, 5, PROTO_TCP, 5, 0, 24);
            send_frame();
            settle();
        end
        write_mask(ALL_FIELDS);
    endtask

    task automatic test_long_frames();
        gen_frame(1, 15, PROTO_TCP, 15, 0, 0);
        send_frame();
        settle();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct,
                               input logic [NUM_FIELDS-1:0] mask);
        int sent_bytes, r, ihl, doff, cut;
        logic [7:0] proto;
        bit ipv4;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_mask(mask);
        sent_bytes = 0;
        while (sent_bytes < 40) begin
            r = $urandom_range(0, 99);
            ipv4 = (r >= 8);
            proto = (r < 50) ? PROTO_TCP : (r < 70) ? PROTO_UDP :
                    (r < 80) ? PROTO_ICMP : 8'($urandom);
            ihl = ($urandom_range(0, 99) < 75) ? 5 : $urandom_range(0, 15);
            doff = ($urandom_range(0, 99) < 75) ? 5 : $urandom_range(0, 15);
            cut = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 80) : 0;
            gen_frame(ipv4, ihl, proto, doff, $urandom_range(0, 8), cut);
            sent_bytes += frame_buf.size();
            send_frame();
        end
        settle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_packet_byte = 8'h00;
        s_last_byte = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        frame_count = 0;
        enable_mask = ALL_FIELDS;
        foreach (hdr_mem[i]) hdr_mem[i] = 8'h00;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 25;
        rx_idle_pct = 62;
        test_default_mask();
        test_protocols();
        test_short_frames();

        tx_idle_pct = 62;
        rx_idle_pct = 25;
        test_extreme_bytes();
        test_field_masks();
        test_random(62, 25, NUM_FIELDS'($urandom));

        test_random(0, 0, ALL_FIELDS);
        test_long_frames();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/eth_l4x_pkg.sv
rtl/core/eth_ipv4_l4_header_field_extractor_core.sv
test/eth_ipv4_l4_header_field_extractor_core_test.sv
